// ===== hw/rtl/tdcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdcc_pkg
// Shared types and constants for the tick driven calendar clock core.
// ----------------------------------------------------------------------------
package tdcc_pkg;

  // default width of the free-running tick counter
  localparam int unsigned TICK_COUNT_WIDTH_DEF = 32;

  // request codes carried in req_type
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // reset values
  localparam logic [15:0] TPS_RESET   = 16'd1000;
  localparam logic [15:0] YEAR_RESET  = 16'd1970;
  localparam logic [3:0]  MONTH_RESET = 4'd1;
  localparam logic [4:0]  DAY_RESET   = 5'd1;

  // input transaction payload
  typedef struct packed {
    logic        req_type;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
  } tdcc_in_t;

  // result transaction payload
  typedef struct packed {
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [31:0] tick_total;
  } tdcc_out_t;

endpackage

// ===== hw/rtl/tick_driven_calendar_clock_core.sv =====
// ----------------------------------------------------------------------------
// tick_driven_calendar_clock_core
// Tick count, sub-second prescaler and Gregorian calendar, advanced by ticks.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one transaction: a timer tick
//   (req_type = REQ_TICK) or a calendar load (req_type = REQ_LOAD).
//   Every accepted transaction produces exactly one result on
//   out_valid/out_stall/out_data: the calendar and tick count after it.
//   cfg_valid/cfg_ready/cfg_data write ticks_per_second; cfg_ready is always
//   high, writes are expected only while the block is idle.
// Throughput:
//   one transaction per cycle unless in_stall is high; the result appears in
//   the cycle after acceptance. The whole carry chain (prescaler, seconds up to
//   years, month length with leap test) is a single combinational pass into
//   the state and result registers.
// Stalls:
//   the result register holds while out_stall is high; a new transaction is
//   still taken when the result register is empty or drains in that cycle,
//   otherwise in_stall is raised.
// Reset:
//   synchronous, active low; clears the tick count and prescaler, sets the
//   calendar to 1970-01-01 00:00:00 and ticks_per_second to 1000.
// ----------------------------------------------------------------------------
module tick_driven_calendar_clock_core #(
  parameter int unsigned TICK_COUNT_WIDTH = tdcc_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tdcc_pkg::tdcc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tdcc_pkg::tdcc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  // calendar limits and month codes
  localparam logic [6:0]  SEC_LIMIT  = 7'd60;
  localparam logic [5:0]  HOUR_LIMIT = 6'd24;
  localparam logic [3:0]  DEC        = 4'd12;
  localparam logic [3:0]  JAN        = 4'd1;
  localparam logic [3:0]  FEB        = 4'd2;
  localparam logic [3:0]  MAR        = 4'd3;
  localparam logic [3:0]  MAY        = 4'd5;
  localparam logic [3:0]  JUL        = 4'd7;
  localparam logic [3:0]  AUG        = 4'd8;
  localparam logic [3:0]  OCT        = 4'd10;
  // multiplicative inverse of 25 modulo 2^16 and the divisibility bound
  localparam logic [15:0] INV25      = 16'd23593;
  localparam logic [15:0] DIV25_MAX  = 16'd2621;

  // state registers
  logic [15:0]                 tps_r;
  logic [TICK_COUNT_WIDTH-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [15:0]                 sub_r, sub_nxt;
  logic [15:0]                 year_r, year_nxt;
  logic [3:0]                  month_r, month_nxt;
  logic [4:0]                  day_r, day_nxt;
  logic [4:0]                  hour_r, hour_nxt;
  logic [5:0]                  min_r, min_nxt;
  logic [5:0]                  sec_r, sec_nxt;
  logic                        out_valid_r;
  tdcc_pkg::tdcc_out_t         out_data_r, out_data_nxt;

  logic                        in_acc;
  logic [16:0]                 sub_inc;
  logic [6:0]                  sec_inc, min_inc;
  logic [5:0]                  hour_inc, day_inc;
  logic [15:0]                 year_mul;
  logic                        div4, div16, div25, leap;
  logic [4:0]                  mlen;
  logic [TICK_COUNT_WIDTH+31:0] tick_ext;

  // handshake
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // leap year test: divisible by 100 is divisible by 4 and 25
  assign year_mul = year_r * INV25;
  assign div4     = (year_r[1:0] == 2'd0);
  assign div16    = (year_r[3:0] == 4'd0);
  assign div25    = (year_mul <= DIV25_MAX);
  assign leap     = (div4 & ~div25) | (div16 & div25);

  // month length, invalid months count as 30 days
  always_comb begin
    case (month_r)
      JAN, MAR, MAY, JUL, AUG, OCT, DEC: mlen = 5'd31;
      FEB:                               mlen = leap ? 5'd29 : 5'd28;
      default:                           mlen = 5'd30;
    endcase
  end

  // incremented fields, one bit wider so out-of-range values carry
  assign sub_inc  = {1'b0, sub_r} + 17'd1;
  assign sec_inc  = {1'b0, sec_r} + 7'd1;
  assign min_inc  = {1'b0, min_r} + 7'd1;
  assign hour_inc = {1'b0, hour_r} + 6'd1;
  assign day_inc  = {1'b0, day_r} + 6'd1;

  // next state: tick with carry chain, or load
  always_comb begin
    tick_cnt_nxt = tick_cnt_r;
    sub_nxt      = sub_r;
    year_nxt     = year_r;
    month_nxt    = month_r;
    day_nxt      = day_r;
    hour_nxt     = hour_r;
    min_nxt      = min_r;
    sec_nxt      = sec_r;
    if (in_data.req_type == tdcc_pkg::REQ_LOAD) begin
      year_nxt  = {2'b00, in_data.load_year};
      month_nxt = in_data.load_month;
      day_nxt   = in_data.load_day;
      hour_nxt  = in_data.load_hour;
      min_nxt   = in_data.load_minute;
      sec_nxt   = in_data.load_second;
    end else begin
      tick_cnt_nxt = tick_cnt_r + {{(TICK_COUNT_WIDTH-1){1'b0}}, 1'b1};
      if (sub_inc >= {1'b0, tps_r}) begin
        sub_nxt = '0;
        if (sec_inc < SEC_LIMIT) begin
          sec_nxt = sec_inc[5:0];
        end else begin
          sec_nxt = '0;
          if (min_inc < SEC_LIMIT) begin
            min_nxt = min_inc[5:0];
          end else begin
            min_nxt = '0;
            if (hour_inc < HOUR_LIMIT) begin
              hour_nxt = hour_inc[4:0];
            end else begin
              hour_nxt = '0;
              if (day_inc <= {1'b0, mlen}) begin
                day_nxt = day_inc[4:0];
              end else begin
                day_nxt = tdcc_pkg::DAY_RESET;
                if (month_r >= DEC) begin
                  month_nxt = JAN;
                  year_nxt  = year_r + 16'd1;
                end else begin
                  month_nxt = month_r + 4'd1;
                end
              end
            end
          end
        end
      end else begin
        sub_nxt = sub_inc[15:0];
      end
    end
  end

  // result built from the next state
  assign tick_ext = {32'd0, tick_cnt_nxt};
  always_comb begin
    out_data_nxt.cur_year   = year_nxt;
    out_data_nxt.cur_month  = month_nxt;
    out_data_nxt.cur_day    = day_nxt;
    out_data_nxt.cur_hour   = hour_nxt;
    out_data_nxt.cur_minute = min_nxt;
    out_data_nxt.cur_second = sec_nxt;
    out_data_nxt.tick_total = tick_ext[31:0];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= tdcc_pkg::TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tps_r <= cfg_data;
    end
  end

  // clock and calendar state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r <= '0;
      sub_r      <= '0;
      year_r     <= tdcc_pkg::YEAR_RESET;
      month_r    <= tdcc_pkg::MONTH_RESET;
      day_r      <= tdcc_pkg::DAY_RESET;
      hour_r     <= '0;
      min_r      <= '0;
      sec_r      <= '0;
    end else if (in_acc) begin
      tick_cnt_r <= tick_cnt_nxt;
      sub_r      <= sub_nxt;
      year_r     <= year_nxt;
      month_r    <= month_nxt;
      day_r      <= day_nxt;
      hour_r     <= hour_nxt;
      min_r      <= min_nxt;
      sec_r      <= sec_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== hw/rtl/tdcc_checker.sv =====
// ----------------------------------------------------------------------------
// tdcc_checker
// Port-level checks for the tick driven calendar clock core.
// ----------------------------------------------------------------------------
module tdcc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input tdcc_pkg::tdcc_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input tdcc_pkg::tdcc_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every accepted transaction shows a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // a load's result shows the loaded year, month, day and second
  a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == tdcc_pkg::REQ_LOAD) |=>
      (out_data.cur_year == {2'b00, $past(in_data.load_year)}) &&
      (out_data.cur_month == $past(in_data.load_month)) &&
      (out_data.cur_day == $past(in_data.load_day)) &&
      (out_data.cur_second == $past(in_data.load_second)))
    else $error("load not reflected in result");

endmodule

bind tick_driven_calendar_clock_core tdcc_checker u_tdcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== bench/tick_driven_calendar_clock_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tick_driven_calendar_clock_core_test
// Self-checking bench for the calendar clock core. A behavioural calendar
// runs beside the block and predicts every result; directed tests cover
// rollovers, leap years, odd loads and prescaler settings, then random
// traffic with boundary loads runs under random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tick_driven_calendar_clock_core_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 60;
  localparam int PHASE_ITEMS  = 150;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // block ports
  logic                in_valid  = 1'b0;
  logic                in_stall;
  tdcc_pkg::tdcc_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tdcc_pkg::tdcc_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [15:0]         cfg_data  = '0;

  tick_driven_calendar_clock_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // predicted calendar state
  logic [31:0] cal_ticks;
  logic [15:0] cal_subsec;
  logic [15:0] cal_tps;
  logic [15:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  cal_hour;
  logic [5:0]  cal_min;
  logic [5:0]  cal_sec;

  tdcc_pkg::tdcc_out_t expected_times[$];
  int        error_count = 0;
  int        cycle_count = 0;

  // sender and receiver idling controls
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int          burst_left = 0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [15:0] stall_pattern = 16'h0;
  logic [3:0]  stall_phase = 4'h0;

  // advance the predicted calendar by one transaction and return the time
  function automatic tdcc_pkg::tdcc_out_t clock_next_time(input tdcc_pkg::tdcc_in_t item);
    tdcc_pkg::tdcc_out_t res;
    int        month_days;
    bit        leap;
    if (item.req_type == tdcc_pkg::REQ_TICK) begin
      cal_ticks = cal_ticks + 32'd1;
      if (int'(cal_subsec) + 1 >= int'(cal_tps)) begin
        cal_subsec = '0;
        if (int'(cal_sec) + 1 < 60) begin
          cal_sec = cal_sec + 6'd1;
        end else begin
          cal_sec = '0;
          if (int'(cal_min) + 1 < 60) begin
            cal_min = cal_min + 6'd1;
          end else begin
            cal_min = '0;
            if (int'(cal_hour) + 1 < 24) begin
              cal_hour = cal_hour + 5'd1;
            end else begin
              cal_hour = '0;
              // month length, invalid months count as 30 days
              leap = ((cal_year % 4 == 0) && (cal_year % 100 != 0)) || (cal_year % 400 == 0);
              case (cal_month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 31;
                4'd2:    month_days = leap ? 29 : 28;
                default: month_days = 30;
              endcase
              if (int'(cal_day) + 1 <= month_days) begin
                cal_day = cal_day + 5'd1;
              end else begin
                cal_day = 5'd1;
                if (cal_month >= 4'd12) begin
                  cal_month = 4'd1;
                  cal_year  = cal_year + 16'd1;
                end else begin
                  cal_month = cal_month + 4'd1;
                end
              end
            end
          end
        end
      end else begin
        cal_subsec = cal_subsec + 16'd1;
      end
    end else begin
      cal_year  = {2'b00, item.load_year};
      cal_month = item.load_month;
      cal_day   = item.load_day;
      cal_hour  = item.load_hour;
      cal_min   = item.load_minute;
      cal_sec   = item.load_second;
    end
    res.cur_year   = cal_year;
    res.cur_month  = cal_month;
    res.cur_day    = cal_day;
    res.cur_hour   = cal_hour;
    res.cur_minute = cal_min;
    res.cur_second = cal_sec;
    res.tick_total = cal_ticks;
    return res;
  endfunction

  // transaction with random payload bits and the given request code
  function automatic tdcc_pkg::tdcc_in_t random_item(input logic req);
    tdcc_pkg::tdcc_in_t it;
    logic [63:0]        bits;
    bits = {$urandom, $urandom};
    it = bits[$bits(tdcc_pkg::tdcc_in_t)-1:0];
    it.req_type = req;
    return it;
  endfunction

  function automatic tdcc_pkg::tdcc_in_t load_item(input int y, input int mo, input int d,
                                                   input int h, input int mi, input int s);
    tdcc_pkg::tdcc_in_t it;
    it.req_type    = tdcc_pkg::REQ_LOAD;
    it.load_year   = 14'(y);
    it.load_month  = 4'(mo);
    it.load_day    = 5'(d);
    it.load_hour   = 5'(h);
    it.load_minute = 6'(mi);
    it.load_second = 6'(s);
    return it;
  endfunction

  // load just short of a carry, with century and leap years favoured
  function automatic tdcc_pkg::tdcc_in_t boundary_load();
    int y;
    int mo;
    int d;
    int h;
    int mi;
    case ($urandom_range(0, 3))
      0:       y = $urandom_range(0, 16383);
      1:       y = 100 * $urandom_range(0, 163);
      2:       y = 4 * $urandom_range(0, 4095);
      default: y = 4 * $urandom_range(0, 4094) + $urandom_range(1, 3);
    endcase
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    d  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(26, 31);
    h  = ($urandom_range(0, 7) == 0) ? $urandom_range(22, 31) : 23;
    mi = ($urandom_range(0, 7) == 0) ? $urandom_range(58, 63) : 59;
    return load_item(y, mo, d, h, mi, $urandom_range(56, 63));
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // offer one transaction, in bursts with random gaps, and predict its result
  task automatic send_item(input tdcc_pkg::tdcc_in_t item);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    expected_times.push_back(clock_next_time(item));
  endtask

  // stop offering and wait until every predicted result has arrived
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_times.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_ticks_per_second(input logic [15:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cal_tps = value;
  endtask

  // state straight out of reset
  task automatic test_reset_state();
    repeat (2) send_item(random_item(tdcc_pkg::REQ_TICK));
  endtask

  // all-zero and all-ones loads, then carry out of every out-of-range field
  task automatic test_load_extremes();
    send_item(load_item(0, 0, 0, 0, 0, 0));
    send_item(load_item(16383, 15, 31, 31, 63, 63));
    write_ticks_per_second(16'd1);
    send_item(random_item(tdcc_pkg::REQ_TICK));
  endtask

  // year end, leap rules and invalid month or day carries
  task automatic test_calendar_rollovers();
    send_item(load_item(1999, 12, 31, 23, 59, 59));
    send_item(random_item(tdcc_pkg::REQ_TICK));
    send_item(load_item(2000, 2, 28, 23, 59, 59));
    send_item(random_item(tdcc_pkg::REQ_TICK));
    send_item(load_item(1900, 2, 28, 23, 59, 59));
    send_item(random_item(tdcc_pkg::REQ_TICK));
    send_item(load_item(2024, 2, 29, 23, 59, 59));
    send_item(random_item(tdcc_pkg::REQ_TICK));
    send_item(load_item(2021, 0, 30, 23, 59, 59));
    send_item(random_item(tdcc_pkg::REQ_TICK));
    send_item(load_item(2021, 13, 30, 23, 59, 59));
    send_item(random_item(tdcc_pkg::REQ_TICK));
    send_item(load_item(2021, 6, 0, 23, 59, 59));
    send_item(random_item(tdcc_pkg::REQ_TICK));
  endtask

  // zero rate, rate lowered under the running count, widest rate
  task automatic test_prescaler_settings();
    write_ticks_per_second(16'd0);
    repeat (2) send_item(random_item(tdcc_pkg::REQ_TICK));
    write_ticks_per_second(16'd1000);
    repeat (4) send_item(random_item(tdcc_pkg::REQ_TICK));
    write_ticks_per_second(16'd3);
    send_item(random_item(tdcc_pkg::REQ_TICK));
    write_ticks_per_second(16'hFFFF);
    send_item(random_item(tdcc_pkg::REQ_TICK));
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    hold_requests++;
    repeat (24) send_item(random_item(tdcc_pkg::REQ_TICK));
    wait_for_results();
    gaps_on = 1'b1;
  endtask

  // boundary loads followed by ticks, plus random loads and tick bursts
  task automatic test_random_traffic();
    int sent;
    int tick_span;
    int choice;
    logic [15:0] rate;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0, 4, 8: rate = 16'd1;
        1:       rate = 16'd0;
        2:       rate = 16'd2;
        3:       rate = 16'($urandom_range(3, 6));
        5:       rate = 16'd60;
        6:       rate = 16'($urandom_range(7, 65534));
        7:       rate = 16'd4;
        default: rate = 16'hFFFF;
      endcase
      write_ticks_per_second(rate);
      gaps_on   = (phase % 3) != 2;
      stalls_on = (phase % 4) != 3;
      tick_span = (cal_tps >= 1 && cal_tps <= 6) ? 3 * cal_tps : 8;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        choice = $urandom_range(0, 9);
        if (choice < 7) begin
          send_item(boundary_load());
          sent++;
          repeat ($urandom_range(1, tick_span)) begin
            send_item(random_item(tdcc_pkg::REQ_TICK));
            sent++;
          end
        end else if (choice == 7) begin
          send_item(random_item(tdcc_pkg::REQ_LOAD));
          sent++;
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_item(random_item(tdcc_pkg::REQ_TICK));
            sent++;
          end
        end
      end
    end
  endtask

  // receiver stall: long hold on request, else none while stalls are off, else a rotating random pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!stalls_on) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= stall_pattern[stall_phase];
      stall_phase = stall_phase + 4'd1;
      if (stall_phase == 4'd0) begin
        case ($urandom_range(0, 2))
          0:       stall_pattern = 16'($urandom);
          1:       stall_pattern = 16'($urandom & $urandom);
          default: stall_pattern = 16'h0;
        endcase
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    tdcc_pkg::tdcc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_times.size() == 0) begin
        report_mismatch("result with nothing expected, tick_total", out_data.tick_total, 0);
      end else begin
        want = expected_times.pop_front();
        if (out_data.cur_year !== want.cur_year)
          report_mismatch("cur_year", out_data.cur_year, want.cur_year);
        if (out_data.cur_month !== want.cur_month)
          report_mismatch("cur_month", out_data.cur_month, want.cur_month);
        if (out_data.cur_day !== want.cur_day)
          report_mismatch("cur_day", out_data.cur_day, want.cur_day);
        if (out_data.cur_hour !== want.cur_hour)
          report_mismatch("cur_hour", out_data.cur_hour, want.cur_hour);
        if (out_data.cur_minute !== want.cur_minute)
          report_mismatch("cur_minute", out_data.cur_minute, want.cur_minute);
        if (out_data.cur_second !== want.cur_second)
          report_mismatch("cur_second", out_data.cur_second, want.cur_second);
        if (out_data.tick_total !== want.tick_total)
          report_mismatch("tick_total", out_data.tick_total, want.tick_total);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // test sequence
  initial begin
    cal_ticks  = '0;
    cal_subsec = '0;
    cal_tps    = tdcc_pkg::TPS_RESET;
    cal_year   = tdcc_pkg::YEAR_RESET;
    cal_month  = tdcc_pkg::MONTH_RESET;
    cal_day    = tdcc_pkg::DAY_RESET;
    cal_hour   = '0;
    cal_min    = '0;
    cal_sec    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_load_extremes();
    test_calendar_rollovers();
    test_prescaler_settings();
    test_output_backpressure();
    test_random_traffic();

    wait_for_results();
    repeat (4) @(posedge clk);
    if (expected_times.size() != 0)
      report_mismatch("results never delivered", 0, expected_times.size());
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
